// File: hdl/satb_pkg.sv
// shared types and constants for the alarm timer bank
// no dependencies; used by satb_ctrl, satb_datapath and software_alarm_timer_bank
package satb_pkg;

    localparam int OPCODE_W = 3;
    localparam int INDEX_W  = 4;
    localparam int PERIOD_W = 31;
    localparam int AMODE_W  = 2;
    localparam int TIME_W   = 32;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;
    localparam int MINP_W   = 16;
    localparam int IDLE_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // command codes
    typedef enum logic [OPCODE_W-1:0] {
        OP_CREATE = 3'd0,
        OP_ARM    = 3'd1,
        OP_START  = 3'd2,
        OP_STOP   = 3'd3,
        OP_FREE   = 3'd4,
        OP_QUERY  = 3'd5,
        OP_SETPER = 3'd6,
        OP_SCAN   = 3'd7
    } opcode_t;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_REPLY   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIRE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STS_NO_FREE   = 3'd1;
    localparam logic [STATUS_W-1:0] STS_SHORT     = 3'd2;
    localparam logic [STATUS_W-1:0] STS_BAD_MODE  = 3'd3;
    localparam logic [STATUS_W-1:0] STS_NOT_ALLOC = 3'd4;
    localparam logic [STATUS_W-1:0] STS_NOT_ARMED = 3'd5;

    // alarm modes
    localparam logic [AMODE_W-1:0] MODE_SINGLE = 2'd0;
    localparam logic [AMODE_W-1:0] MODE_SEMI   = 2'd1;
    localparam logic [AMODE_W-1:0] MODE_AUTO   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_SCANS = 2'd1;

    // reset values
    localparam logic [MINP_W-1:0] MIN_PERIOD_RST = 16'd10;
    localparam logic [IDLE_W-1:0] IDLE_SCANS_RST = 2'd2;
    localparam logic [IDLE_W-1:0] IDLE_CNT_MAX   = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic scan;
        logic summary;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_scan;
        logic scan_end;
    } dp_stat_t;

endpackage

// File: hdl/software_alarm_timer_bank.sv
// top level of the alarm timer bank: controller plus datapath
// depends on satb_pkg, satb_ctrl, satb_datapath
//
// usage
//  - command channel: drive opcode, timer_index, timer_period, alarm_mode and
//    now_ms and raise start; the transaction is taken at the clock edge where
//    start is high and busy is low. inputs need only be valid at that edge
//  - results come out on kind/status/result_index/is_active/current_mode/
//    idle/last, each valid for exactly one cycle while result_valid is high;
//    the receiver cannot stall, every strobed result must be captured
//  - config channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
//    index 0 is the minimum period, index 1 the idle scan count, other
//    indexes are dropped. cfg_ready is always high; write only while idle
//  - a plain command gives its single reply from the exec state through the
//    result register; busy drops in the cycle the reply shows
//  - scan walks one slot per cycle over min(NUM_TIMERS,16) slots, one fire
//    result per due slot, then the summary with last set; a new command is
//    taken only after busy has dropped at the end of the scan or reply
//  - reset: all slots free, idle count zero, min period 10 ms, idle scans 2;
//    no clearing pass is needed
module software_alarm_timer_bank #(
    parameter int NUM_TIMERS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [satb_pkg::OPCODE_W-1:0]        opcode,
    input  logic [satb_pkg::INDEX_W-1:0]         timer_index,
    input  logic [satb_pkg::PERIOD_W-1:0]        timer_period,
    input  logic [satb_pkg::AMODE_W-1:0]         alarm_mode,
    input  logic [satb_pkg::TIME_W-1:0]          now_ms,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [satb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [satb_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                 result_valid,
    output logic [satb_pkg::KIND_W-1:0]          kind,
    output logic [satb_pkg::STATUS_W-1:0]        status,
    output logic [satb_pkg::INDEX_W-1:0]         result_index,
    output logic                                 is_active,
    output logic [satb_pkg::AMODE_W-1:0]         current_mode,
    output logic                                 idle,
    output logic                                 last
);
    import satb_pkg::*;

    // only the first sixteen slots are addressable
    localparam int BANK   = (NUM_TIMERS < 16) ? NUM_TIMERS : 16;
    localparam int SLOT_W = (BANK > 1) ? $clog2(BANK) : 1;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // config writes are always taken
    assign cfg_ready = 1'b1;

    satb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    satb_datapath #(
        .BANK   (BANK),
        .SLOT_W (SLOT_W)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .opcode       (opcode),
        .timer_index  (timer_index),
        .timer_period (timer_period),
        .alarm_mode   (alarm_mode),
        .now_ms       (now_ms),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .kind         (kind),
        .status       (status),
        .result_index (result_index),
        .is_active    (is_active),
        .current_mode (current_mode),
        .idle         (idle),
        .last         (last)
    );

`ifndef ASSERT_OFF
    // the bank goes free exactly when the closing result of a transaction shows
    a_free_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (result_valid && last))
        else $error("busy dropped without a final result");

    // results only come out of a transaction in progress
    a_result_in_txn: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result strobe outside a transaction");

    // a fire result is never the final one of its scan
    a_fire_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (kind == KIND_FIRE)) |-> (!last && busy))
        else $error("fire result marked last or after scan end");
`endif

endmodule

// File: hdl/satb_ctrl.sv
// sequencing state machine for the alarm timer bank
// depends on satb_pkg (dp_cmd_t, dp_stat_t)
module satb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  satb_pkg::dp_stat_t  stat,
    output satb_pkg::dp_cmd_t   cmd,
    output logic                busy
);
    import satb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_SUMMARY
    } state_t;

    state_t state_reg;
    logic   busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= stat.in_scan ? ST_SCAN : ST_EXEC;
                        busy_reg  <= 1'b1;
                    end
                end
                ST_EXEC:
                begin
                    state_reg <= ST_IDLE;
                    busy_reg  <= 1'b0;
                end
                ST_SCAN:
                begin
                    if (stat.scan_end)
                        state_reg <= ST_SUMMARY;
                end
                ST_SUMMARY:
                begin
                    state_reg <= ST_IDLE;
                    busy_reg  <= 1'b0;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd.load    = (state_reg == ST_IDLE) && start;
        cmd.exec    = (state_reg == ST_EXEC);
        cmd.scan    = (state_reg == ST_SCAN);
        cmd.summary = (state_reg == ST_SUMMARY);
    end

    assign busy = busy_reg;

endmodule

// File: hdl/satb_datapath.sv
// slot storage, command evaluation, scan step and result register
// depends on satb_pkg (codes, widths, dp_cmd_t, dp_stat_t)
module satb_datapath #(
    parameter int BANK   = 16,
    parameter int SLOT_W = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  satb_pkg::dp_cmd_t                    cmd,
    output satb_pkg::dp_stat_t                   stat,
    input  logic [satb_pkg::OPCODE_W-1:0]        opcode,
    input  logic [satb_pkg::INDEX_W-1:0]         timer_index,
    input  logic [satb_pkg::PERIOD_W-1:0]        timer_period,
    input  logic [satb_pkg::AMODE_W-1:0]         alarm_mode,
    input  logic [satb_pkg::TIME_W-1:0]          now_ms,
    input  logic                                 cfg_we,
    input  logic [satb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [satb_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                 result_valid,
    output logic [satb_pkg::KIND_W-1:0]          kind,
    output logic [satb_pkg::STATUS_W-1:0]        status,
    output logic [satb_pkg::INDEX_W-1:0]         result_index,
    output logic                                 is_active,
    output logic [satb_pkg::AMODE_W-1:0]         current_mode,
    output logic                                 idle,
    output logic                                 last
);
    import satb_pkg::*;

    // latched command
    opcode_t             op_reg;
    logic [INDEX_W-1:0]  idx_reg;
    logic [PERIOD_W-1:0] per_in_reg;
    logic [AMODE_W-1:0]  mode_in_reg;
    logic [TIME_W-1:0]   now_reg;

    // configuration
    logic [MINP_W-1:0] min_period_reg, min_period_next;
    logic [IDLE_W-1:0] idle_scans_reg, idle_scans_next;

    // slot state
    logic [BANK-1:0] used_reg, used_next;
    logic [BANK-1:0] armed_reg, armed_next;
    logic [BANK-1:0] running_reg, running_next;
    logic [AMODE_W-1:0]  mode_mem   [BANK];
    logic [PERIOD_W-1:0] period_mem [BANK];
    logic [TIME_W-1:0]   fire_mem   [BANK];

    // scan state
    logic [SLOT_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic              any_reg, any_next;
    logic [IDLE_W-1:0] idle_cnt_reg, idle_cnt_next;

    // result register
    logic                valid_reg, valid_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [INDEX_W-1:0]  index_reg, index_next;
    logic                active_reg, active_next;
    logic [AMODE_W-1:0]  cmode_reg, cmode_next;
    logic                idle_reg, idle_next;
    logic                last_reg, last_next;

    // storage write port
    logic              mode_we, per_we, fire_we;
    logic [SLOT_W-1:0] wr_slot;

    logic [SLOT_W-1:0]   cmd_slot;
    logic [SLOT_W-1:0]   rd_slot;
    logic                in_range;
    logic                slot_valid;
    logic                too_short;
    logic                free_found;
    logic [SLOT_W-1:0]   free_idx;
    logic [TIME_W-1:0]   elapsed;
    logic                live;
    logic                due;
    logic [AMODE_W-1:0]  mode_rd_reg;
    logic [PERIOD_W-1:0] period_rd_reg;
    logic [TIME_W-1:0]   fire_rd_reg;

    assign cmd_slot   = idx_reg[SLOT_W-1:0];
    assign in_range   = {1'b0, idx_reg} < (INDEX_W+1)'(BANK);
    assign slot_valid = in_range && used_reg[cmd_slot];
    assign too_short  = per_in_reg < PERIOD_W'(min_period_reg);

    // registered read: addressed slot at accept (slot 0 for a scan),
    // then the slot after the one under scan
    assign rd_slot = cmd.load ? (stat.in_scan ? '0 : timer_index[SLOT_W-1:0])
                              : scan_cnt_reg + SLOT_W'(1);

    // wrap-around elapsed time of the slot under scan
    assign elapsed = now_reg - fire_rd_reg;
    assign live    = used_reg[scan_cnt_reg] && running_reg[scan_cnt_reg]
                     && armed_reg[scan_cnt_reg];
    assign due     = live && (elapsed >= {1'b0, period_rd_reg});

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = BANK - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        used_next       = used_reg;
        armed_next      = armed_reg;
        running_next    = running_reg;
        scan_cnt_next   = scan_cnt_reg;
        any_next        = any_reg;
        idle_cnt_next   = idle_cnt_reg;
        min_period_next = min_period_reg;
        idle_scans_next = idle_scans_reg;
        mode_we         = 1'b0;
        per_we          = 1'b0;
        fire_we         = 1'b0;
        wr_slot         = cmd_slot;
        valid_next      = 1'b0;
        kind_next       = KIND_REPLY;
        status_next     = STS_OK;
        index_next      = '0;
        active_next     = 1'b0;
        cmode_next      = '0;
        idle_next       = 1'b0;
        last_next       = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_PERIOD: min_period_next = cfg_data;
                CFG_IDLE_SCANS: idle_scans_next = cfg_data[IDLE_W-1:0];
                default: ;
            endcase
        end

        if (cmd.load)
        begin
            scan_cnt_next = '0;
            any_next      = 1'b0;
        end

        if (cmd.exec)
        begin
            valid_next = 1'b1;
            last_next  = 1'b1;
            case (op_reg)
                OP_CREATE:
                begin
                    if (free_found)
                    begin
                        used_next[free_idx]    = 1'b1;
                        armed_next[free_idx]   = 1'b0;
                        running_next[free_idx] = 1'b0;
                        index_next             = INDEX_W'(free_idx);
                    end
                    else
                        status_next = STS_NO_FREE;
                end
                OP_ARM:
                begin
                    if (too_short)
                        status_next = STS_SHORT;
                    else if (mode_in_reg > MODE_AUTO)
                        status_next = STS_BAD_MODE;
                    else if (!slot_valid)
                        status_next = STS_NOT_ALLOC;
                    else
                    begin
                        armed_next[cmd_slot]   = 1'b1;
                        running_next[cmd_slot] = 1'b1;
                        mode_we = 1'b1;
                        per_we  = 1'b1;
                        fire_we = 1'b1;
                    end
                end
                OP_START:
                begin
                    if (!slot_valid)
                        status_next = STS_NOT_ALLOC;
                    else if (!armed_reg[cmd_slot])
                        status_next = STS_NOT_ARMED;
                    else
                    begin
                        running_next[cmd_slot] = 1'b1;
                        fire_we = 1'b1;
                    end
                end
                OP_STOP:
                begin
                    if (!slot_valid)
                        status_next = STS_NOT_ALLOC;
                    else
                        running_next[cmd_slot] = 1'b0;
                end
                OP_FREE:
                begin
                    if (!slot_valid)
                        status_next = STS_NOT_ALLOC;
                    else
                    begin
                        used_next[cmd_slot]    = 1'b0;
                        armed_next[cmd_slot]   = 1'b0;
                        running_next[cmd_slot] = 1'b0;
                    end
                end
                OP_QUERY:
                begin
                    if (!slot_valid)
                        status_next = STS_NOT_ALLOC;
                    else if (!armed_reg[cmd_slot])
                        status_next = STS_NOT_ARMED;
                    else
                    begin
                        active_next = running_reg[cmd_slot];
                        cmode_next  = mode_rd_reg;
                    end
                end
                OP_SETPER:
                begin
                    if (too_short)
                        status_next = STS_SHORT;
                    else if (!slot_valid)
                        status_next = STS_NOT_ALLOC;
                    else
                        per_we = 1'b1;
                end
                default: ;
            endcase
        end

        // one slot per cycle
        if (cmd.scan)
        begin
            wr_slot       = scan_cnt_reg;
            scan_cnt_next = scan_cnt_reg + SLOT_W'(1);
            any_next      = any_reg || live;
            if (due)
            begin
                valid_next = 1'b1;
                kind_next  = KIND_FIRE;
                index_next = INDEX_W'(scan_cnt_reg);
                fire_we    = 1'b1;
                if (mode_rd_reg != MODE_AUTO)
                    running_next[scan_cnt_reg] = 1'b0;
            end
        end

        if (cmd.summary)
        begin
            if (any_reg)
                idle_cnt_next = '0;
            else if (idle_cnt_reg < IDLE_CNT_MAX)
                idle_cnt_next = idle_cnt_reg + IDLE_W'(1);
            valid_next = 1'b1;
            kind_next  = KIND_SUMMARY;
            last_next  = 1'b1;
            idle_next  = !any_reg && (idle_cnt_next >= idle_scans_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            armed_reg      <= '0;
            running_reg    <= '0;
            scan_cnt_reg   <= '0;
            any_reg        <= 1'b0;
            idle_cnt_reg   <= '0;
            min_period_reg <= MIN_PERIOD_RST;
            idle_scans_reg <= IDLE_SCANS_RST;
            valid_reg      <= 1'b0;
        end
        else
        begin
            used_reg       <= used_next;
            armed_reg      <= armed_next;
            running_reg    <= running_next;
            scan_cnt_reg   <= scan_cnt_next;
            any_reg        <= any_next;
            idle_cnt_reg   <= idle_cnt_next;
            min_period_reg <= min_period_next;
            idle_scans_reg <= idle_scans_next;
            valid_reg      <= valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= opcode_t'(opcode);
            idx_reg     <= timer_index;
            per_in_reg  <= timer_period;
            mode_in_reg <= alarm_mode;
            now_reg     <= now_ms;
        end
        kind_reg   <= kind_next;
        status_reg <= status_next;
        index_reg  <= index_next;
        active_reg <= active_next;
        cmode_reg  <= cmode_next;
        idle_reg   <= idle_next;
        last_reg   <= last_next;
    end

    // slot payload; contents only matter once arm has written them
    always_ff @(posedge clk)
    begin
        if (mode_we)
            mode_mem[wr_slot] <= mode_in_reg;
        if (per_we)
            period_mem[wr_slot] <= per_in_reg;
        if (fire_we)
            fire_mem[wr_slot] <= now_reg;
        mode_rd_reg   <= mode_mem[rd_slot];
        period_rd_reg <= period_mem[rd_slot];
        fire_rd_reg   <= fire_mem[rd_slot];
    end

    assign stat.in_scan  = (opcode == OP_SCAN);
    assign stat.scan_end = (scan_cnt_reg == SLOT_W'(BANK - 1));

    assign result_valid = valid_reg;
    assign kind         = kind_reg;
    assign status       = status_reg;
    assign result_index = index_reg;
    assign is_active    = active_reg;
    assign current_mode = cmode_reg;
    assign idle         = idle_reg;
    assign last         = last_reg;

endmodule

// File: test/tb_software_alarm_timer_bank.sv
// testbench for the alarm timer bank: result tracker class and driving top module
// depends on satb_pkg and the software_alarm_timer_bank rtl
import satb_pkg::*;

localparam int BANK_SLOTS = 16;

typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  index;
    logic                active;
    logic [AMODE_W-1:0]  mode;
    logic                idle;
    logic                last;
} alarm_result_t;

// predicts the bank and holds the results still to come
class alarm_bank_tracker;
    bit                used[BANK_SLOTS];
    bit                armed[BANK_SLOTS];
    bit                running[BANK_SLOTS];
    bit [AMODE_W-1:0]  mode[BANK_SLOTS];
    bit [PERIOD_W-1:0] period[BANK_SLOTS];
    bit [TIME_W-1:0]   last_fire[BANK_SLOTS];
    bit [IDLE_W-1:0]   idle_count;
    bit [MINP_W-1:0]   min_period;
    bit [IDLE_W-1:0]   idle_scans;
    alarm_result_t     awaited[$];
    int                errors;
    int                checked;
    int                fires;

    function new();
        for (int i = 0; i < BANK_SLOTS; i++)
            clear_slot(i);
        idle_count = '0;
        min_period = MIN_PERIOD_RST;
        idle_scans = IDLE_SCANS_RST;
    endfunction

    function void clear_slot(int i);
        used[i]      = 1'b0;
        armed[i]     = 1'b0;
        running[i]   = 1'b0;
        mode[i]      = MODE_SINGLE;
        period[i]    = '0;
        last_fire[i] = '0;
    endfunction

    function int free_slot();
        for (int i = 0; i < BANK_SLOTS; i++)
            if (!used[i])
                return i;
        return -1;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_MIN_PERIOD)
            min_period = data[MINP_W-1:0];
        else if (idx == CFG_IDLE_SCANS)
            idle_scans = data[IDLE_W-1:0];
    endfunction

    function void push_result(logic [KIND_W-1:0] k, logic [STATUS_W-1:0] st,
                              logic [INDEX_W-1:0] ix, logic act, logic [AMODE_W-1:0] md,
                              logic idl, logic lst);
        alarm_result_t r;
        r = '{kind: k, status: st, index: ix, active: act, mode: md, idle: idl, last: lst};
        awaited.push_back(r);
    endfunction

    function void reply_status(logic [STATUS_W-1:0] st);
        push_result(KIND_REPLY, st, '0, 1'b0, MODE_SINGLE, 1'b0, 1'b1);
    endfunction

    // one accepted command: update the slots and queue what it should produce
    function void note_command(opcode_t op, bit [INDEX_W-1:0] idx, bit [PERIOD_W-1:0] per,
                               bit [AMODE_W-1:0] amode, bit [TIME_W-1:0] now);
        int              slot;
        bit              any;
        bit [TIME_W-1:0] elapsed;
        slot = free_slot();
        case (op)
            OP_CREATE:
                if (slot < 0)
                    reply_status(STS_NO_FREE);
                else
                begin
                    clear_slot(slot);
                    used[slot] = 1'b1;
                    push_result(KIND_REPLY, STS_OK, INDEX_W'(slot), 1'b0, MODE_SINGLE,
                                1'b0, 1'b1);
                end
            OP_ARM:
                if (per < min_period)
                    reply_status(STS_SHORT);
                else if (amode > MODE_AUTO)
                    reply_status(STS_BAD_MODE);
                else if (!used[idx])
                    reply_status(STS_NOT_ALLOC);
                else
                begin
                    armed[idx]     = 1'b1;
                    period[idx]    = per;
                    mode[idx]      = amode;
                    running[idx]   = 1'b1;
                    last_fire[idx] = now;
                    reply_status(STS_OK);
                end
            OP_START:
                if (!used[idx])
                    reply_status(STS_NOT_ALLOC);
                else if (!armed[idx])
                    reply_status(STS_NOT_ARMED);
                else
                begin
                    running[idx]   = 1'b1;
                    last_fire[idx] = now;
                    reply_status(STS_OK);
                end
            OP_STOP:
                if (!used[idx])
                    reply_status(STS_NOT_ALLOC);
                else
                begin
                    running[idx] = 1'b0;
                    reply_status(STS_OK);
                end
            OP_FREE:
                if (!used[idx])
                    reply_status(STS_NOT_ALLOC);
                else
                begin
                    clear_slot(idx);
                    reply_status(STS_OK);
                end
            OP_QUERY:
                if (!used[idx])
                    reply_status(STS_NOT_ALLOC);
                else if (!armed[idx])
                    reply_status(STS_NOT_ARMED);
                else
                    push_result(KIND_REPLY, STS_OK, '0, running[idx], mode[idx], 1'b0, 1'b1);
            OP_SETPER:
                if (per < min_period)
                    reply_status(STS_SHORT);
                else if (!used[idx])
                    reply_status(STS_NOT_ALLOC);
                else
                begin
                    period[idx] = per;
                    reply_status(STS_OK);
                end
            default:
            begin
                // scan: ascending slot order, elapsed time wraps modulo 2^32
                any = 1'b0;
                for (int i = 0; i < BANK_SLOTS; i++)
                begin
                    if (used[i] && running[i] && armed[i])
                    begin
                        any = 1'b1;
                        elapsed = now - last_fire[i];
                        if (elapsed >= {1'b0, period[i]})
                        begin
                            push_result(KIND_FIRE, STS_OK, INDEX_W'(i), 1'b0, MODE_SINGLE,
                                        1'b0, 1'b0);
                            last_fire[i] = now;
                            if (mode[i] == MODE_SINGLE || mode[i] == MODE_SEMI)
                                running[i] = 1'b0;
                        end
                    end
                end
                if (any)
                    idle_count = '0;
                else if (idle_count < IDLE_CNT_MAX)
                    idle_count++;
                push_result(KIND_SUMMARY, STS_OK, '0, 1'b0, MODE_SINGLE,
                            !any && idle_count >= idle_scans, 1'b1);
            end
        endcase
    endfunction

    function string describe(alarm_result_t r);
        return $sformatf("kind %0d status %0d index %0d active %0d mode %0d idle %0d last %0d",
                         r.kind, r.status, r.index, r.active, r.mode, r.idle, r.last);
    endfunction

    task report_mismatch(string what);
        errors++;
        if (errors <= 40)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check_result(alarm_result_t got);
        alarm_result_t want;
        if (awaited.size() == 0)
        begin
            report_mismatch({"unexpected result ", describe(got)});
            return;
        end
        want = awaited.pop_front();
        checked++;
        if (want.kind == KIND_FIRE)
            fires++;
        if (got !== want)
            report_mismatch({"got ", describe(got), " want ", describe(want)});
    endtask
endclass

module tb_software_alarm_timer_bank;

    // well past the slowest transaction, a full scan
    localparam int SETTLE_CYCLES = 24;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int RUN_LIMIT     = 2_000_000;
    localparam int PHASE_ITEMS   = 45;

    // codes the package has no name for
    localparam logic [AMODE_W-1:0]   MODE_INVALID = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = 2'd3;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  start        = 1'b0;
    logic                  busy;
    logic [OPCODE_W-1:0]   opcode       = '0;
    logic [INDEX_W-1:0]    timer_index  = '0;
    logic [PERIOD_W-1:0]   timer_period = '0;
    logic [AMODE_W-1:0]    alarm_mode   = '0;
    logic [TIME_W-1:0]     now_ms       = '0;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  result_valid;
    logic [KIND_W-1:0]     kind;
    logic [STATUS_W-1:0]   status;
    logic [INDEX_W-1:0]    result_index;
    logic                  is_active;
    logic [AMODE_W-1:0]    current_mode;
    logic                  idle;
    logic                  last;

    alarm_bank_tracker bank = new();
    alarm_result_t     observed;

    int              idle_pct   = 0;   // chance in percent of a pause after a transaction
    bit [TIME_W-1:0] clock_ms   = '0;  // the millisecond clock the commands carry
    int              commands   = 0;
    int              reg_writes = 0;

    software_alarm_timer_bank i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .timer_index  (timer_index),
        .timer_period (timer_period),
        .alarm_mode   (alarm_mode),
        .now_ms       (now_ms),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .kind         (kind),
        .status       (status),
        .result_index (result_index),
        .is_active    (is_active),
        .current_mode (current_mode),
        .idle         (idle),
        .last         (last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // results cannot be held off: each strobe is sampled mid-cycle, away from the edges
    always @(negedge clk)
    begin
        if (rst_n === 1'b1 && result_valid === 1'b1)
        begin
            observed = {kind, status, result_index, is_active, current_mode, idle, last};
            bank.check_result(observed);
        end
    end

    // one command transaction; called right after a rising edge, returns right
    // after the accepting edge with start still high
    task automatic issue(opcode_t op, bit [INDEX_W-1:0] idx, bit [PERIOD_W-1:0] per,
                         bit [AMODE_W-1:0] amode, bit [TIME_W-1:0] now);
        start        <= 1'b1;
        opcode       <= op;
        timer_index  <= idx;
        timer_period <= per;
        alarm_mode   <= amode;
        now_ms       <= now;
        // busy only moves on rising edges, so its value mid-cycle decides the next edge
        do
            @(negedge clk);
        while (busy !== 1'b0);
        @(posedge clk);
        bank.note_command(op, idx, per, amode, now);
        commands++;
    endtask

    // random sender gap; the fields carry junk while start is low
    task automatic maybe_pause();
        int n;
        if ($urandom_range(99) < idle_pct)
        begin
            n = ($urandom_range(7) == 0) ? $urandom_range(6, 24) : $urandom_range(1, 3);
            start        <= 1'b0;
            opcode       <= OPCODE_W'($urandom);
            timer_index  <= INDEX_W'($urandom);
            timer_period <= PERIOD_W'($urandom);
            alarm_mode   <= AMODE_W'($urandom);
            now_ms       <= TIME_W'($urandom);
            repeat (n) @(posedge clk);
        end
    endtask

    // hold the sender until every awaited result is in and the block is idle
    task automatic wait_all_results();
        start <= 1'b0;
        while (bank.awaited.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(negedge clk);
        while (cfg_ready !== 1'b1);
        @(posedge clk);
        bank.write_register(idx, data);
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // mostly slots that exist, so commands get past the allocation check
    function automatic bit [INDEX_W-1:0] pick_slot();
        int owned[$];
        for (int i = 0; i < BANK_SLOTS; i++)
            if (bank.used[i])
                owned.push_back(i);
        if (owned.size() != 0 && $urandom_range(99) < 85)
            return INDEX_W'(owned[$urandom_range(owned.size() - 1)]);
        return INDEX_W'($urandom_range(BANK_SLOTS - 1));
    endfunction

    // periods mostly just above the minimum, some below it, some over the whole range
    function automatic bit [PERIOD_W-1:0] pick_period();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return PERIOD_W'(bank.min_period) + PERIOD_W'($urandom_range(0, 40));
        if (r < 85)
            return PERIOD_W'($urandom_range(0, int'(bank.min_period) - 1));
        return PERIOD_W'($urandom);
    endfunction

    task automatic random_command();
        int                pick;
        int                step_max;
        opcode_t           op;
        bit [AMODE_W-1:0]  amode;
        bit [TIME_W-1:0]   now;
        pick = $urandom_range(99);
        if (pick < 10)
            op = OP_CREATE;
        else if (pick < 28)
            op = OP_ARM;
        else if (pick < 37)
            op = OP_START;
        else if (pick < 44)
            op = OP_STOP;
        else if (pick < 51)
            op = OP_FREE;
        else if (pick < 61)
            op = OP_QUERY;
        else if (pick < 69)
            op = OP_SETPER;
        else
            op = OP_SCAN;
        amode = ($urandom_range(11) == 0) ? MODE_INVALID : AMODE_W'($urandom_range(2));
        // time steps scale with the minimum period so timers keep firing
        step_max = (int'(bank.min_period) + 40) / 3;
        if ($urandom_range(39) == 0)
            clock_ms += $urandom;
        else
            clock_ms += $urandom_range(0, step_max);
        // now and then a stray time, which may even run backwards
        now = ($urandom_range(29) == 0) ? TIME_W'($urandom) : clock_ms;
        issue(op, pick_slot(), pick_period(), amode, now);
    endtask

    initial
    begin
        #(RUN_LIMIT);
        $display("software_alarm_timer_bank verification failed");
        $finish;
    end

    initial
    begin
        int wait_cycles;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset configuration: minimum period 10, idle after 2 scans
        issue(OP_QUERY, 4'd15, '0, MODE_INVALID, '1);           // empty bank, top index
        issue(OP_SCAN, '0, '0, MODE_SINGLE, '0);                // first empty scan
        issue(OP_SCAN, '0, '0, MODE_SINGLE, '0);                // idle threshold reached
        issue(OP_CREATE, '0, '0, MODE_SINGLE, '0);
        issue(OP_START, 4'd0, '0, MODE_SINGLE, 32'd1);          // allocated, never armed
        issue(OP_QUERY, 4'd0, '0, MODE_SINGLE, 32'd1);          // allocated, never armed
        issue(OP_STOP, 4'd0, '0, MODE_SINGLE, 32'd1);           // stop of unarmed slot is fine
        issue(OP_ARM, 4'd0, 31'd9, MODE_INVALID, '0);           // short period wins over mode
        issue(OP_ARM, 4'd0, 31'd10, MODE_INVALID, '0);          // bad mode on an allocated slot
        issue(OP_ARM, 4'd5, 31'd10, MODE_SINGLE, '0);           // slot not allocated
        issue(OP_ARM, 4'd0, 31'd10, MODE_SINGLE, 32'hFFFF_FFF8);
        issue(OP_SETPER, 4'd7, 31'd5, MODE_SINGLE, '0);         // short period checked first
        issue(OP_SETPER, 4'd7, 31'd100, MODE_SINGLE, '0);       // then allocation
        issue(OP_CREATE, '0, '0, MODE_SINGLE, '0);
        issue(OP_ARM, 4'd1, '1, MODE_AUTO, '0);                 // longest period
        issue(OP_CREATE, '0, '0, MODE_SINGLE, '0);
        issue(OP_ARM, 4'd2, 31'd20, MODE_SEMI, 32'hFFFF_FFF0);
        issue(OP_QUERY, 4'd0, '0, MODE_SINGLE, '0);
        issue(OP_SCAN, '0, '0, MODE_SINGLE, 32'd2);             // slot 0 due across the wrap
        issue(OP_SCAN, '0, '0, MODE_SINGLE, 32'd4);             // slot 2 due, slot 0 stopped
        issue(OP_START, 4'd0, '0, MODE_SINGLE, 32'd4);
        issue(OP_SETPER, 4'd0, 31'd30, MODE_SINGLE, 32'd4);
        issue(OP_FREE, 4'd1, '0, MODE_SINGLE, 32'd5);
        issue(OP_QUERY, 4'd1, '0, MODE_SINGLE, 32'd5);          // freed slot
        issue(OP_CREATE, '0, '0, MODE_SINGLE, 32'd5);           // lowest free slot again
        issue(OP_SCAN, '0, '0, MODE_SINGLE, 32'd100);

        // random phases, each under its own register setting
        for (int ph = 0; ph < 4; ph++)
        begin
            wait_all_results();
            case (ph)
                0:
                begin
                    write_register(CFG_MIN_PERIOD, 16'd1);
                    write_register(CFG_IDLE_SCANS, 16'd1);
                end
                1:
                begin
                    write_register(CFG_MIN_PERIOD, 16'hFFFF);
                    write_register(CFG_IDLE_SCANS, 16'd3);
                end
                2:
                begin
                    write_register(CFG_MIN_PERIOD, CFG_DATA_W'($urandom_range(2, 300)));
                    write_register(CFG_IDLE_SCANS, CFG_DATA_W'($urandom_range(1, 3)));
                end
                default:
                begin
                    write_register(CFG_UNUSED, CFG_DATA_W'($urandom));  // must be dropped
                    write_register(CFG_MIN_PERIOD, MIN_PERIOD_RST);
                    write_register(CFG_IDLE_SCANS, IDLE_SCANS_RST);
                end
            endcase
            // phase 2 runs with no sender gaps at all
            idle_pct = (ph == 2) ? 0 : 32;
            clock_ms = $urandom;

            // fill the bank and ask for one slot more
            if (ph == 0 || ph == 2)
            begin
                while (bank.free_slot() >= 0)
                    issue(OP_CREATE, '0, '0, MODE_SINGLE, clock_ms);
                issue(OP_CREATE, '0, '0, MODE_SINGLE, clock_ms);
            end

            repeat (PHASE_ITEMS)
            begin
                random_command();
                maybe_pause();
            end
        end

        // drain, then give the block time to show anything extra
        start <= 1'b0;
        for (wait_cycles = 0; wait_cycles < DRAIN_LIMIT && bank.awaited.size() != 0;
             wait_cycles++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (bank.awaited.size() != 0)
            bank.report_mismatch($sformatf("%0d results never arrived", bank.awaited.size()));

        $display("covered %0d commands of all eight kinds over five register settings (%0d writes)",
                 commands, reg_writes);
        $display("compared %0d results, %0d of them timer fires", bank.checked, bank.fires);
        if (bank.errors == 0)
            $display("software_alarm_timer_bank verification clean");
        else
            $display("software_alarm_timer_bank verification failed");
        $finish;
    end

endmodule
